// ===== rtl/srpd_pkg.sv =====
// Shared constants, codes and types of the source route packet deframer.
`default_nettype none
package srpd_pkg;

    // Largest path or payload length in bytes.
    localparam int MAX_PACKET = 64;
    // Bytes allowed after the start byte before the packet is cut off.
    localparam int BYTE_LIMIT = 2 * MAX_PACKET + 3;

    // Saturating counters must hold one past their limit.
    localparam int BC_W = $clog2(BYTE_LIMIT + 2);
    localparam int PC_W = $clog2(MAX_PACKET + 2);

    // Queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [2:0] CFG_START   = 3'd0;
    localparam logic [2:0] CFG_DIVIDER = 3'd1;
    localparam logic [2:0] CFG_END     = 3'd2;
    localparam logic [2:0] CFG_ESCAPE  = 3'd3;
    localparam logic [2:0] CFG_POINTER = 3'd4;
    localparam logic [2:0] CFG_OWN_ID  = 3'd5;

    // Kind of an output word.
    typedef enum logic [1:0] {
        KIND_PATH    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2
    } t_kind;

    // Routing status given at the end of a packet.
    typedef enum logic [1:0] {
        ST_FORWARD  = 2'd0,
        ST_HERE     = 2'd1,
        ST_NOPTR    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // One queue entry: one output word, or two path words for a rewritten pointer.
    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        t_status    status;
        logic [7:0] hop;
        logic       pair;
        logic [7:0] second;
    } t_entry;

    // Write side of the queue.
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    // Read side of the queue.
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

endpackage
`default_nettype wire

// ===== rtl/srpd_if.sv =====
// Valid/ready channel interfaces for input bytes and output words.
`default_nettype none
interface srpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface srpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [1:0] item_kind;
    logic [1:0] route_status;
    logic [7:0] next_hop;
    logic       last_of_run;

    modport source (output valid, output data_byte, output item_kind, output route_status,
                    output next_hop, output last_of_run, input ready);
    modport sink (input valid, input data_byte, input item_kind, input route_status,
                  input next_hop, input last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/srpd_front.sv =====
// Front part: framing state machine, path rewriting and status classification.
`default_nettype none
module srpd_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire  [2:0]       i_cfg_idx,
    input  wire  [7:0]       i_cfg_data,
    input  wire              i_valid,
    input  wire  [7:0]       i_rx_byte,
    input  wire              i_full,
    output logic             o_ready,
    output srpd_pkg::t_push  o_push
);

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_PATH    = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_ESCAPE  = 4'b1000
    } t_phase;

    // Configuration registers.
    logic [7:0] r_start, r_divider, r_end, r_escape, r_pointer, r_own_id;

    // Packet state.
    t_phase                   r_phase, n_phase;
    logic [srpd_pkg::BC_W-1:0] r_bc, n_bc;
    logic [srpd_pkg::PC_W-1:0] r_pc, n_pc;
    logic [srpd_pkg::PC_W-1:0] r_yc, n_yc;
    logic                     r_pending, n_pending;
    logic                     r_found, n_found;
    logic                     r_captured, n_captured;
    logic [7:0]               r_hop, n_hop;

    logic accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= 8'd123;
            r_divider <= 8'd124;
            r_end     <= 8'd125;
            r_escape  <= 8'd92;
            r_pointer <= 8'd94;
            r_own_id  <= 8'd48;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srpd_pkg::CFG_START:   r_start   <= i_cfg_data;
                srpd_pkg::CFG_DIVIDER: r_divider <= i_cfg_data;
                srpd_pkg::CFG_END:     r_end     <= i_cfg_data;
                srpd_pkg::CFG_ESCAPE:  r_escape  <= i_cfg_data;
                srpd_pkg::CFG_POINTER: r_pointer <= i_cfg_data;
                srpd_pkg::CFG_OWN_ID:  r_own_id  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state and queue entry for the accepted byte.
    always_comb begin
        logic [srpd_pkg::BC_W-1:0] bc_inc;
        logic [srpd_pkg::PC_W-1:0] pc_inc;
        logic [srpd_pkg::PC_W-1:0] yc_inc;
        logic                      give_st;
        logic                      store_payload;
        srpd_pkg::t_status         st;

        n_phase    = r_phase;
        n_bc       = r_bc;
        n_pc       = r_pc;
        n_yc       = r_yc;
        n_pending  = r_pending;
        n_found    = r_found;
        n_captured = r_captured;
        n_hop      = r_hop;

        give_st       = 1'b0;
        store_payload = 1'b0;
        st            = srpd_pkg::ST_OVERFLOW;

        bc_inc = (r_bc <= srpd_pkg::BC_W'(srpd_pkg::BYTE_LIMIT)) ? r_bc + 1'b1 : r_bc;
        pc_inc = (r_pc <= srpd_pkg::PC_W'(srpd_pkg::MAX_PACKET)) ? r_pc + 1'b1 : r_pc;
        yc_inc = (r_yc <= srpd_pkg::PC_W'(srpd_pkg::MAX_PACKET)) ? r_yc + 1'b1 : r_yc;

        o_push.valid        = 1'b0;
        o_push.entry.data   = i_rx_byte;
        o_push.entry.kind   = srpd_pkg::KIND_PATH;
        o_push.entry.status = srpd_pkg::ST_FORWARD;
        o_push.entry.hop    = 8'd0;
        o_push.entry.pair   = 1'b0;
        o_push.entry.second = r_pointer;

        if (accept) begin
            if (r_phase == PH_HUNT) begin
                // Drop bytes until the start byte opens a packet.
                if (i_rx_byte == r_start) begin
                    n_phase = PH_PATH;
                end
            end else begin
                n_bc = bc_inc;
                if (bc_inc > srpd_pkg::BC_W'(srpd_pkg::BYTE_LIMIT)) begin
                    give_st = 1'b1;
                end else begin
                    case (r_phase)
                        PH_PATH: begin
                            if (i_rx_byte == r_divider) begin
                                // A pointer held at the divider leaves unchanged.
                                if (r_pending) begin
                                    o_push.valid      = 1'b1;
                                    o_push.entry.data = r_pointer;
                                    n_pending         = 1'b0;
                                end
                                n_phase = PH_PAYLOAD;
                            end else begin
                                n_pc = pc_inc;
                                if (pc_inc > srpd_pkg::PC_W'(srpd_pkg::MAX_PACKET)) begin
                                    give_st = 1'b1;
                                end else if (r_pending) begin
                                    // Byte after the pointer is the next hop.
                                    n_hop             = i_rx_byte;
                                    n_captured        = 1'b1;
                                    n_pending         = 1'b0;
                                    o_push.valid      = 1'b1;
                                    o_push.entry.data = r_own_id;
                                    o_push.entry.pair = 1'b1;
                                end else if (i_rx_byte == r_pointer && !r_found) begin
                                    n_found   = 1'b1;
                                    n_pending = 1'b1;
                                end else begin
                                    o_push.valid = 1'b1;
                                end
                            end
                        end
                        PH_PAYLOAD: begin
                            if (i_rx_byte == r_end) begin
                                give_st = 1'b1;
                                if (!r_found) begin
                                    st = srpd_pkg::ST_NOPTR;
                                end else if (r_captured) begin
                                    st = srpd_pkg::ST_FORWARD;
                                end else begin
                                    st = srpd_pkg::ST_HERE;
                                end
                            end else if (i_rx_byte == r_escape) begin
                                n_phase = PH_ESCAPE;
                            end else begin
                                store_payload = 1'b1;
                            end
                        end
                        PH_ESCAPE: begin
                            n_phase       = PH_PAYLOAD;
                            store_payload = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end

            // Payload bytes are counted and passed on.
            if (store_payload) begin
                n_yc = yc_inc;
                if (yc_inc > srpd_pkg::PC_W'(srpd_pkg::MAX_PACKET)) begin
                    give_st = 1'b1;
                end else begin
                    o_push.valid      = 1'b1;
                    o_push.entry.kind = srpd_pkg::KIND_PAYLOAD;
                end
            end

            // Any status closes the packet and returns to hunting.
            if (give_st) begin
                o_push.valid        = 1'b1;
                o_push.entry.data   = 8'd0;
                o_push.entry.kind   = srpd_pkg::KIND_STATUS;
                o_push.entry.status = st;
                o_push.entry.hop    = (st == srpd_pkg::ST_FORWARD) ? r_hop : 8'd0;
                o_push.entry.pair   = 1'b0;
            end

            if (give_st || (r_phase == PH_HUNT && i_rx_byte == r_start)) begin
                n_phase    = give_st ? PH_HUNT : PH_PATH;
                n_bc       = '0;
                n_pc       = '0;
                n_yc       = '0;
                n_pending  = 1'b0;
                n_found    = 1'b0;
                n_captured = 1'b0;
                n_hop      = 8'd0;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_bc       <= '0;
            r_pc       <= '0;
            r_yc       <= '0;
            r_pending  <= 1'b0;
            r_found    <= 1'b0;
            r_captured <= 1'b0;
            r_hop      <= 8'd0;
        end else begin
            r_phase    <= n_phase;
            r_bc       <= n_bc;
            r_pc       <= n_pc;
            r_yc       <= n_yc;
            r_pending  <= n_pending;
            r_found    <= n_found;
            r_captured <= n_captured;
            r_hop      <= n_hop;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/srpd_queue.sv =====
// Short FIFO of classified entries between the front and back parts.
`default_nettype none
module srpd_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  srpd_pkg::t_push  i_push,
    input  wire              i_pop,
    output logic             o_full,
    output srpd_pkg::t_head  o_head
);

    srpd_pkg::t_entry r_mem [srpd_pkg::Q_DEPTH];

    logic [srpd_pkg::Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [srpd_pkg::Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [srpd_pkg::Q_CNT_W-1:0] r_count, n_count;

    logic do_push, do_pop;

    assign o_full       = (r_count == srpd_pkg::Q_CNT_W'(srpd_pkg::Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == srpd_pkg::Q_PTR_W'(srpd_pkg::Q_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == srpd_pkg::Q_PTR_W'(srpd_pkg::Q_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/srpd_back.sv =====
// Back part: turns queue entries into output words, splitting pointer pairs.
`default_nettype none
module srpd_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  srpd_pkg::t_head  i_head,
    input  wire              i_ready,
    output logic             o_pop,
    output logic             o_valid,
    output logic [7:0]       o_data_byte,
    output logic [1:0]       o_item_kind,
    output logic [1:0]       o_route_status,
    output logic [7:0]       o_next_hop,
    output logic             o_last_of_run
);

    // Set while the second word of a pair is on the port.
    logic r_half, n_half;
    logic take;

    assign take    = i_head.valid && i_ready;
    assign o_valid = i_head.valid;
    assign o_pop   = take && (!i_head.entry.pair || r_half);

    // Word selection: the second word of a pair is a plain path byte.
    always_comb begin
        if (r_half) begin
            o_data_byte    = i_head.entry.second;
            o_item_kind    = 2'(srpd_pkg::KIND_PATH);
            o_route_status = 2'(srpd_pkg::ST_FORWARD);
            o_next_hop     = 8'd0;
        end else begin
            o_data_byte    = i_head.entry.data;
            o_item_kind    = 2'(i_head.entry.kind);
            o_route_status = 2'(i_head.entry.status);
            o_next_hop     = i_head.entry.hop;
        end
        o_last_of_run = !i_head.entry.pair || r_half;
        n_half        = take ? (i_head.entry.pair && !r_half) : r_half;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
        end else begin
            r_half <= n_half;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/source_route_packet_deframer.sv =====
// Top level of the source route packet deframer.
// The deframer accepts one received byte per clock cycle while its queue is not full,
// and emits path, payload and end-of-packet status words on its output channel. Most
// bytes cause zero or one output word; the byte after the first pointer causes two
// (own id, then the pointer), which leave the output port as two separate words. A
// four-entry queue between the framing logic and the output stage absorbs those pairs
// and lets either side stall on its own, so input throughput stays at one byte per
// cycle while the output keeps up. Each output word is registered in the queue before
// it reaches the output port. Configuration registers are written through a plain
// write port and take effect on the next byte; no clearing pass is needed after reset.
`default_nettype none
module source_route_packet_deframer (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [2:0] i_cfg_idx,
    input  wire  [7:0] i_cfg_data,
    srpd_in_if.sink    i_in,
    srpd_out_if.source o_out
);

    srpd_pkg::t_push push;
    srpd_pkg::t_head head;
    logic            full;
    logic            pop;

    srpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_in.valid),
        .i_rx_byte  (i_in.rx_byte),
        .i_full     (full),
        .o_ready    (i_in.ready),
        .o_push     (push)
    );

    srpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    srpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_ready        (o_out.ready),
        .o_pop          (pop),
        .o_valid        (o_out.valid),
        .o_data_byte    (o_out.data_byte),
        .o_item_kind    (o_out.item_kind),
        .o_route_status (o_out.route_status),
        .o_next_hop     (o_out.next_hop),
        .o_last_of_run  (o_out.last_of_run)
    );

endmodule
`default_nettype wire

// ===== test/deframer_check_pkg.sv =====
// Scoreboard class that predicts and checks the deframer's output words.
package deframer_check_pkg;
    import srpd_pkg::*;

    // Framing phase of the predictor.
    typedef enum logic [1:0] {
        HUNTING      = 2'd0,
        IN_PATH      = 2'd1,
        IN_PAYLOAD   = 2'd2,
        AFTER_ESCAPE = 2'd3
    } framing_phase_t;

    // One output word, field by field.
    typedef struct {
        logic [7:0] data_byte;
        t_kind      item_kind;
        t_status    route_status;
        logic [7:0] next_hop;
        logic       last_of_run;
    } deframer_word_t;

    class deframer_scoreboard;
        logic [7:0] reg_file [6];
        int mismatches;

        local deframer_word_t expected_words [$];
        local framing_phase_t phase;
        local int byte_count;
        local int path_count;
        local int payload_count;
        local bit pointer_pending;
        local bit pointer_found;
        local bit hop_captured;
        local logic [7:0] hop_value;

        function new();
            reg_file[CFG_START]   = 8'd123;
            reg_file[CFG_DIVIDER] = 8'd124;
            reg_file[CFG_END]     = 8'd125;
            reg_file[CFG_ESCAPE]  = 8'd92;
            reg_file[CFG_POINTER] = 8'd94;
            reg_file[CFG_OWN_ID]  = 8'd48;
            mismatches = 0;
            clear_packet();
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        local function void clear_packet();
            phase = HUNTING;
            byte_count = 0;
            path_count = 0;
            payload_count = 0;
            pointer_pending = 1'b0;
            pointer_found = 1'b0;
            hop_captured = 1'b0;
            hop_value = 8'h00;
        endfunction

        // Data words carry a zero status and hop.
        local function void push_word(logic [7:0] data, t_kind kind);
            deframer_word_t w;
            w.data_byte = data;
            w.item_kind = kind;
            w.route_status = ST_FORWARD;
            w.next_hop = 8'h00;
            w.last_of_run = 1'b0;
            expected_words.push_back(w);
        endfunction

        // A status word ends the packet and sends the framer back to hunting.
        local function void give_status(t_status st);
            deframer_word_t w;
            w.data_byte = 8'h00;
            w.item_kind = KIND_STATUS;
            w.route_status = st;
            w.next_hop = (st == ST_FORWARD) ? hop_value : 8'h00;
            w.last_of_run = 1'b0;
            expected_words.push_back(w);
            clear_packet();
        endfunction

        // Predict the output words caused by one accepted input word.
        function void note_byte(logic [7:0] b);
            int first;
            first = expected_words.size();
            if (phase == HUNTING) begin
                if (b == reg_file[CFG_START]) begin
                    clear_packet();
                    phase = IN_PATH;
                end
            end else begin
                // The byte count saturates one past its limit.
                if (byte_count <= BYTE_LIMIT) byte_count++;
                if (byte_count > BYTE_LIMIT) begin
                    give_status(ST_OVERFLOW);
                end else if (phase == IN_PATH) begin
                    if (b == reg_file[CFG_DIVIDER]) begin
                        // A pointer held back at the divider is last: it passes unchanged.
                        if (pointer_pending) begin
                            push_word(reg_file[CFG_POINTER], KIND_PATH);
                            pointer_pending = 1'b0;
                        end
                        phase = IN_PAYLOAD;
                    end else begin
                        if (path_count <= MAX_PACKET) path_count++;
                        if (path_count > MAX_PACKET) begin
                            give_status(ST_OVERFLOW);
                        end else if (pointer_pending) begin
                            // The byte after the pointer is the next hop.
                            hop_value = b;
                            hop_captured = 1'b1;
                            pointer_pending = 1'b0;
                            push_word(reg_file[CFG_OWN_ID], KIND_PATH);
                            push_word(reg_file[CFG_POINTER], KIND_PATH);
                        end else if (b == reg_file[CFG_POINTER] && !pointer_found) begin
                            pointer_found = 1'b1;
                            pointer_pending = 1'b1;
                        end else begin
                            push_word(b, KIND_PATH);
                        end
                    end
                end else if (phase == IN_PAYLOAD && b == reg_file[CFG_END]) begin
                    if (!pointer_found) give_status(ST_NOPTR);
                    else give_status(hop_captured ? ST_FORWARD : ST_HERE);
                end else if (phase == IN_PAYLOAD && b == reg_file[CFG_ESCAPE]) begin
                    phase = AFTER_ESCAPE;
                end else begin
                    // Plain or escaped payload byte.
                    phase = IN_PAYLOAD;
                    if (payload_count <= MAX_PACKET) payload_count++;
                    if (payload_count > MAX_PACKET) give_status(ST_OVERFLOW);
                    else push_word(b, KIND_PAYLOAD);
                end
            end
            if (expected_words.size() > first)
                expected_words[expected_words.size() - 1].last_of_run = 1'b1;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) report($sformatf("%s is %02h, expected %02h", name, got, want));
        endtask

        // Compare one accepted output word with the oldest prediction.
        task check_word(deframer_word_t got);
            deframer_word_t want;
            if (expected_words.size() == 0) begin
                report($sformatf("output word with nothing expected: data %02h kind %0d",
                                 got.data_byte, got.item_kind));
            end else begin
                want = expected_words.pop_front();
                compare_field("data_byte", got.data_byte, want.data_byte);
                compare_field("item_kind", 8'(got.item_kind), 8'(want.item_kind));
                compare_field("route_status", 8'(got.route_status), 8'(want.route_status));
                compare_field("next_hop", got.next_hop, want.next_hop);
                compare_field("last_of_run", 8'(got.last_of_run), 8'(want.last_of_run));
            end
        endtask
    endclass

endpackage

// ===== test/source_route_packet_deframer_tb.sv =====
// Self-checking testbench of the source route packet deframer.
module source_route_packet_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srpd_pkg::*;
    import deframer_check_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT = 1000;

    // Shapes of generated byte sequences.
    typedef enum logic [2:0] {
        PKT_ROUTED,
        PKT_FOR_US,
        PKT_NO_POINTER,
        PKT_TRUNCATED,
        PKT_NOISE,
        PKT_PATH_OVERFLOW,
        PKT_PAYLOAD_OVERFLOW,
        PKT_LENGTH_OVERFLOW
    } packet_shape_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    srpd_in_if in_ch ();
    srpd_out_if out_ch ();

    deframer_scoreboard sb;
    int items_sent = 0;
    bit gaps_on = 1'b0;
    bit quiet_tail = 1'b0;

    source_route_packet_deframer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output stalls come in bursts; none in the tail of the run.
    initial begin : ready_driver
        int n;
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 6);
            end else begin
                out_ch.ready <= 1'b1;
                n = $urandom_range(1, 12);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    // Note accepted input words before checking output words of the same edge.
    always @(posedge i_clk) begin : monitor
        deframer_word_t got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.rx_byte);
            if (out_ch.valid && out_ch.ready) begin
                got.data_byte = out_ch.data_byte;
                got.item_kind = t_kind'(out_ch.item_kind);
                got.route_status = t_status'(out_ch.route_status);
                got.next_hop = out_ch.next_hop;
                got.last_of_run = out_ch.last_of_run;
                sb.check_word(got);
            end
        end
    end

    // End the run when no word moves on either side for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic logic [7:0] rand_except(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        while (v == a || v == b) v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    // Offer one input word, possibly after a gap, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.reg_file[idx] = value;
    endtask

    // Let the block drain, then write all six registers.
    task automatic apply_config(input logic [7:0] s, input logic [7:0] d, input logic [7:0] e,
                                input logic [7:0] x, input logic [7:0] p,
                                input logic [7:0] own);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_START, s);
        write_reg(CFG_DIVIDER, d);
        write_reg(CFG_END, e);
        write_reg(CFG_ESCAPE, x);
        write_reg(CFG_POINTER, p);
        write_reg(CFG_OWN_ID, own);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hand-picked words with the reset settings: every marker, stray markers,
    // escaped markers, a pointer last in the path, an empty path, and a
    // pointer directly after the first pointer.
    task automatic send_directed();
        logic [7:0] s, d, e, x, p;
        logic [7:0] seq [$];
        s = sb.reg_file[CFG_START];
        d = sb.reg_file[CFG_DIVIDER];
        e = sb.reg_file[CFG_END];
        x = sb.reg_file[CFG_ESCAPE];
        p = sb.reg_file[CFG_POINTER];
        gaps_on = 1'b1;
        seq = '{8'hFF,
                s, 8'h00, p, 8'hFF, p, d, 8'h00, x, e, x, x, d, s, e,
                s, p, d, e,
                s, d, e,
                s, e, p, p, d, e};
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // Build one byte sequence of the given shape from the current settings and send it.
    task automatic send_packet(input packet_shape_t shape);
        int path_len, body_len, ptr_pos, idx;
        logic [7:0] s, d, e, x, p;
        logic [7:0] stream [$];
        s = sb.reg_file[CFG_START];
        d = sb.reg_file[CFG_DIVIDER];
        e = sb.reg_file[CFG_END];
        x = sb.reg_file[CFG_ESCAPE];
        p = sb.reg_file[CFG_POINTER];
        gaps_on = !quiet_tail && ($urandom_range(0, 3) != 0);

        // Mostly short paths and payloads, now and then a long one.
        path_len = $urandom_range(0, 6);
        if ($urandom_range(0, 9) == 0) path_len = $urandom_range(7, MAX_PACKET);
        body_len = $urandom_range(0, 8);
        if ($urandom_range(0, 9) == 0) body_len = $urandom_range(9, MAX_PACKET);
        case (shape)
            PKT_PATH_OVERFLOW: path_len = MAX_PACKET + 1;
            PKT_PAYLOAD_OVERFLOW: begin
                path_len = $urandom_range(0, 6);
                body_len = MAX_PACKET + 1;
            end
            PKT_LENGTH_OVERFLOW: begin
                path_len = MAX_PACKET - 4;
                body_len = MAX_PACKET - 4;
            end
            PKT_ROUTED: if (path_len < 2) path_len = 2;
            PKT_FOR_US: if (path_len < 1) path_len = 1;
            default: ;
        endcase
        if (shape == PKT_FOR_US) ptr_pos = path_len - 1;
        else if (shape == PKT_NO_POINTER || path_len < 2) ptr_pos = -1;
        else ptr_pos = $urandom_range(0, path_len - 2);

        if (shape == PKT_NOISE) begin
            repeat ($urandom_range(1, 8)) stream.push_back(rand_except(s, s));
        end else begin
            stream.push_back(s);
            // Later pointers may follow the first one; they pass through, but one right after it is the hop.
            for (idx = 0; idx < path_len; idx++) begin
                if (idx == ptr_pos)
                    stream.push_back(p);
                else if (ptr_pos >= 0 && idx > ptr_pos && $urandom_range(0, 5) == 0)
                    stream.push_back(p);
                else
                    stream.push_back(rand_except(d, p));
            end
            if (shape != PKT_TRUNCATED) stream.push_back(d);
            // Escapes are frequent in the length overflow case to push the byte count.
            for (idx = 0; idx < body_len; idx++) begin
                if ($urandom_range(0, 7) == 0 ||
                    (shape == PKT_LENGTH_OVERFLOW && $urandom_range(0, 2) == 0)) begin
                    stream.push_back(x);
                    stream.push_back(8'($urandom_range(0, 255)));
                end else begin
                    stream.push_back(rand_except(e, x));
                end
            end
            if (shape != PKT_TRUNCATED) stream.push_back(e);
        end
        foreach (stream[i]) send_byte(stream[i]);
    endtask

    // Mostly well-formed packets, with some noise, broken and overlong ones.
    task automatic run_traffic(input int n_items);
        int goal, pick;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) send_packet(PKT_ROUTED);
            else if (pick < 67) send_packet(PKT_FOR_US);
            else if (pick < 77) send_packet(PKT_NO_POINTER);
            else if (pick < 87) send_packet(PKT_TRUNCATED);
            else if (pick < 96) send_packet(PKT_NOISE);
            else if (pick < 97) send_packet(PKT_PATH_OVERFLOW);
            else if (pick < 98) send_packet(PKT_PAYLOAD_OVERFLOW);
            else send_packet(PKT_LENGTH_OVERFLOW);
        end
    endtask

    initial begin : main
        logic [7:0] pick [6];
        int i, j;
        bit clash;
        sb = new();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_START;
        i_cfg_data <= 8'h00;
        in_ch.valid <= 1'b0;
        in_ch.rx_byte <= 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        run_traffic(100);

        // Extreme settings, with each overflow forced once.
        apply_config(8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h00);
        send_packet(PKT_PATH_OVERFLOW);
        send_packet(PKT_PAYLOAD_OVERFLOW);
        send_packet(PKT_LENGTH_OVERFLOW);
        run_traffic(80);

        apply_config(8'hFF, 8'h00, 8'hFE, 8'h01, 8'h7F, 8'hFF);
        run_traffic(80);

        // Random markers, all distinct; the own id may match one of them.
        for (i = 0; i < 6; i++) begin
            clash = 1'b1;
            while (clash) begin
                pick[i] = 8'($urandom_range(0, 255));
                clash = 1'b0;
                for (j = 0; j < i; j++) if (pick[j] == pick[i] && i < 5) clash = 1'b1;
            end
        end
        apply_config(pick[0], pick[1], pick[2], pick[3], pick[4], pick[5]);
        run_traffic(80);

        // Fully random settings; markers may coincide.
        for (i = 0; i < 6; i++) pick[i] = 8'($urandom_range(0, 255));
        apply_config(pick[0], pick[1], pick[2], pick[3], pick[4], pick[5]);
        run_traffic(70);

        // Back to the reset settings, with no idling on either side.
        apply_config(8'd123, 8'd124, 8'd125, 8'd92, 8'd94, 8'd48);
        quiet_tail = 1'b1;
        run_traffic(100);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) sb.report($sformatf("%0d words never arrived", sb.pending()));

        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
